@@ hdl/pgds_pkg.sv @@
package pgds_pkg;

    // grid size defaults
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // field widths
    localparam int CELL_W = 16;
    localparam int CFG_W  = 7;
    localparam int GAIN_W = 16;
    localparam int IDX_W  = 2;
    localparam int DATA_W = 16;

    // arithmetic widths
    localparam int SUM_W  = CELL_W + 2;
    localparam int LAP_W  = CELL_W + 3;
    localparam int PROD_W = LAP_W + GAIN_W + 1;
    localparam int RND_W  = PROD_W - 16;
    localparam int RES_W  = RND_W + 1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [IDX_W-1:0] CFG_COLS = 2'd1;
    localparam logic [IDX_W-1:0] CFG_GAIN = 2'd2;

    // configuration reset values
    localparam logic [CFG_W-1:0]  ROWS_RESET = 7'd64;
    localparam logic [CFG_W-1:0]  COLS_RESET = 7'd64;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd0;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    // read phases of one emit: center, row neighbors, column neighbors,
    // then one phase to catch the last read word
    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_ME   = 3'd0;
    localparam logic [PH_W-1:0] PH_UP   = 3'd1;
    localparam logic [PH_W-1:0] PH_DN   = 3'd2;
    localparam logic [PH_W-1:0] PH_RT   = 3'd3;
    localparam logic [PH_W-1:0] PH_LF   = 3'd4;
    localparam logic [PH_W-1:0] PH_LAST = 3'd5;

    // rounding offset for the Q0.16 gain product
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(32768);

    // saturation limits
    localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'(32767);
    localparam logic signed [RES_W-1:0] SAT_MIN = -RES_W'(32768);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_RND
    } t_state;

endpackage

@@ hdl/pgds_ram.sv @@
module pgds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hdl/periodic_grid_diffusion_step.sv @@
// One explicit diffusion step on a wrapping grid held in a single memory.
// A load word (operation 0) writes the next cell in raster order in the
// cycle it is accepted; busy stays low, so loads go at one per cycle while
// no emit is in progress. An emit word (operation 1) reads the cell and its
// four wrapped neighbors one at a time through the memory's single read
// port, multiplies the Laplacian by the gain, rounds, adds the center and
// saturates; busy holds off new words through the read, multiply and round
// states, and o_result_valid, registered from the round state, is high for
// one cycle. The result is shown once and cannot be held off; a new word
// may be accepted in the cycle it is shown. Unloaded cells read as garbage.
module periodic_grid_diffusion_step #(
    parameter int MAX_ROWS = pgds_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = pgds_pkg::MAX_COLS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_operation,
    input  logic signed [pgds_pkg::CELL_W-1:0] i_cell_value,
    // result channel
    output logic                         o_result_valid,
    output logic signed [pgds_pkg::CELL_W-1:0] o_updated_value,
    output logic                         o_is_last,
    // configuration channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pgds_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [pgds_pkg::DATA_W-1:0]  i_cfg_data
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RSZ_W  = $clog2(MAX_ROWS + 1);
    localparam int CSZ_W  = $clog2(MAX_COLS + 1);
    localparam int RCMP_W = (RSZ_W > pgds_pkg::CFG_W) ? RSZ_W : pgds_pkg::CFG_W;
    localparam int CCMP_W = (CSZ_W > pgds_pkg::CFG_W) ? CSZ_W : pgds_pkg::CFG_W;
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    logic [pgds_pkg::CFG_W-1:0]  r_rows_in_use;
    logic [pgds_pkg::CFG_W-1:0]  r_cols_in_use;
    logic [pgds_pkg::GAIN_W-1:0] r_diffusion_gain;

    // raster positions
    logic [ROW_W-1:0] r_ld_row, n_ld_row, r_em_row, n_em_row;
    logic [COL_W-1:0] r_ld_col, n_ld_col, r_em_col, n_em_col;

    // stencil positions of the emit in progress
    logic [ROW_W-1:0] r_row, r_up, r_dn;
    logic [COL_W-1:0] r_col, r_rt, r_lf;
    logic             r_last;

    // sequencer
    pgds_pkg::t_state r_state, n_state;
    logic [pgds_pkg::PH_W-1:0] r_phase;

    // datapath
    logic signed [pgds_pkg::CELL_W-1:0] r_me;
    logic signed [pgds_pkg::SUM_W-1:0]  r_sum;
    logic signed [pgds_pkg::PROD_W-1:0] r_prod;

    // memory ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [pgds_pkg::CELL_W-1:0] ram_rdata;

    logic [RSZ_W-1:0] nr;
    logic [CSZ_W-1:0] nc;
    logic [RCMP_W-1:0] rows_ext;
    logic [CCMP_W-1:0] cols_ext;

    logic acc_load, acc_emit;
    logic [ROW_W-1:0] ld_row, em_row, em_up, em_dn, rd_row;
    logic [COL_W-1:0] ld_col, em_col, em_rt, em_lf, rd_col;
    logic [RSZ_W-1:0] em_row_inc, ld_row_inc;
    logic [CSZ_W-1:0] em_col_inc, ld_col_inc;

    logic signed [pgds_pkg::LAP_W-1:0]  lap;
    logic signed [pgds_pkg::RND_W-1:0]  rnd;
    logic signed [pgds_pkg::RES_W-1:0]  res;
    logic signed [pgds_pkg::CELL_W-1:0] sat;

    assign o_cfg_ready = 1'b1;
    assign acc_load = start && !busy && (i_operation == pgds_pkg::OP_LOAD);
    assign acc_emit = start && !busy && (i_operation == pgds_pkg::OP_EMIT);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use    <= pgds_pkg::ROWS_RESET;
            r_cols_in_use    <= pgds_pkg::COLS_RESET;
            r_diffusion_gain <= pgds_pkg::GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pgds_pkg::CFG_ROWS: r_rows_in_use <= i_cfg_data[pgds_pkg::CFG_W-1:0];
                pgds_pkg::CFG_COLS: r_cols_in_use <= i_cfg_data[pgds_pkg::CFG_W-1:0];
                pgds_pkg::CFG_GAIN: r_diffusion_gain <= i_cfg_data[pgds_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective grid size: zero counts as one, clamp to the maximum
    assign rows_ext = RCMP_W'(r_rows_in_use);
    assign cols_ext = CCMP_W'(r_cols_in_use);
    always_comb begin
        if (rows_ext == '0) begin
            nr = RSZ_W'(1);
        end else if (rows_ext > RCMP_W'(MAX_ROWS)) begin
            nr = RSZ_W'(MAX_ROWS);
        end else begin
            nr = rows_ext[RSZ_W-1:0];
        end
        if (cols_ext == '0) begin
            nc = CSZ_W'(1);
        end else if (cols_ext > CCMP_W'(MAX_COLS)) begin
            nc = CSZ_W'(MAX_COLS);
        end else begin
            nc = cols_ext[CSZ_W-1:0];
        end
    end

    // positions with stale counters taken as zero
    assign ld_row = (RSZ_W'(r_ld_row) >= nr) ? '0 : r_ld_row;
    assign ld_col = (CSZ_W'(r_ld_col) >= nc) ? '0 : r_ld_col;
    assign em_row = (RSZ_W'(r_em_row) >= nr) ? '0 : r_em_row;
    assign em_col = (CSZ_W'(r_em_col) >= nc) ? '0 : r_em_col;

    assign ld_row_inc = RSZ_W'(ld_row) + RSZ_W'(1);
    assign ld_col_inc = CSZ_W'(ld_col) + CSZ_W'(1);
    assign em_row_inc = RSZ_W'(em_row) + RSZ_W'(1);
    assign em_col_inc = CSZ_W'(em_col) + CSZ_W'(1);

    // wrapped neighbors
    assign em_up = (em_row_inc >= nr) ? '0 : em_row_inc[ROW_W-1:0];
    assign em_dn = (em_row == '0) ? ROW_W'(nr - RSZ_W'(1)) : em_row - ROW_W'(1);
    assign em_rt = (em_col_inc >= nc) ? '0 : em_col_inc[COL_W-1:0];
    assign em_lf = (em_col == '0) ? COL_W'(nc - CSZ_W'(1)) : em_col - COL_W'(1);

    // raster advance for both counters
    always_comb begin
        n_ld_row = r_ld_row;
        n_ld_col = r_ld_col;
        n_em_row = r_em_row;
        n_em_col = r_em_col;
        if (acc_load) begin
            if (ld_col_inc >= nc) begin
                n_ld_col = '0;
                n_ld_row = (ld_row_inc >= nr) ? '0 : ld_row_inc[ROW_W-1:0];
            end else begin
                n_ld_row = ld_row;
                n_ld_col = ld_col_inc[COL_W-1:0];
            end
        end
        if (acc_emit) begin
            if (em_col_inc >= nc) begin
                n_em_col = '0;
                n_em_row = em_up;
            end else begin
                n_em_row = em_row;
                n_em_col = em_col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_row <= '0;
            r_ld_col <= '0;
            r_em_row <= '0;
            r_em_col <= '0;
        end else begin
            r_ld_row <= n_ld_row;
            r_ld_col <= n_ld_col;
            r_em_row <= n_em_row;
            r_em_col <= n_em_col;
        end
    end

    // capture stencil positions at emit accept
    always_ff @(posedge i_clk) begin
        if (acc_emit) begin
            r_row  <= em_row;
            r_col  <= em_col;
            r_up   <= em_up;
            r_dn   <= em_dn;
            r_rt   <= em_rt;
            r_lf   <= em_lf;
            r_last <= (RSZ_W'(em_row) == nr - RSZ_W'(1))
                   && (CSZ_W'(em_col) == nc - CSZ_W'(1));
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pgds_pkg::ST_IDLE: if (acc_emit) n_state = pgds_pkg::ST_READ;
            pgds_pkg::ST_READ: if (r_phase == pgds_pkg::PH_LAST) n_state = pgds_pkg::ST_MUL;
            pgds_pkg::ST_MUL:  n_state = pgds_pkg::ST_RND;
            pgds_pkg::ST_RND:  n_state = pgds_pkg::ST_IDLE;
            default:           n_state = pgds_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: busy and read position per phase
    always_comb begin
        busy   = (r_state != pgds_pkg::ST_IDLE);
        rd_row = r_row;
        rd_col = r_col;
        unique case (r_phase)
            pgds_pkg::PH_UP: rd_row = r_up;
            pgds_pkg::PH_DN: rd_row = r_dn;
            pgds_pkg::PH_RT: rd_col = r_rt;
            pgds_pkg::PH_LF: rd_col = r_lf;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pgds_pkg::ST_IDLE;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            if (acc_emit) begin
                r_phase <= pgds_pkg::PH_ME;
            end else if (r_state == pgds_pkg::ST_READ) begin
                r_phase <= r_phase + pgds_pkg::PH_W'(1);
            end
        end
    end

    // memory addressing
    assign ram_we    = acc_load;
    assign ram_waddr = ADDR_W'(ADDR_W'(ld_row) * ADDR_W'(MAX_COLS)) + ADDR_W'(ld_col);
    assign ram_raddr = ADDR_W'(ADDR_W'(rd_row) * ADDR_W'(MAX_COLS)) + ADDR_W'(rd_col);

    pgds_ram #(
        .WIDTH (pgds_pkg::CELL_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_grid (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_cell_value),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // gather center and neighbor sum, one word behind the read address
    always_ff @(posedge i_clk) begin
        if (acc_emit) begin
            r_sum <= '0;
        end else if (r_state == pgds_pkg::ST_READ && r_phase != pgds_pkg::PH_ME) begin
            if (r_phase == pgds_pkg::PH_UP) begin
                r_me <= ram_rdata;
            end else begin
                r_sum <= r_sum + pgds_pkg::SUM_W'(signed'(ram_rdata));
            end
        end
    end

    // laplacian times gain
    assign lap = pgds_pkg::LAP_W'(r_sum) - (pgds_pkg::LAP_W'(r_me) <<< 2);
    always_ff @(posedge i_clk) begin
        if (r_state == pgds_pkg::ST_MUL) begin
            r_prod <= pgds_pkg::PROD_W'(lap)
                    * pgds_pkg::PROD_W'(signed'({1'b0, r_diffusion_gain}));
        end
    end

    // round to nearest, add to center, saturate
    assign rnd = pgds_pkg::RND_W'((r_prod + pgds_pkg::RND_HALF) >>> 16);
    assign res = pgds_pkg::RES_W'(r_me) + pgds_pkg::RES_W'(rnd);
    always_comb begin
        if (res > pgds_pkg::SAT_MAX) begin
            sat = pgds_pkg::CELL_W'(pgds_pkg::SAT_MAX);
        end else if (res < pgds_pkg::SAT_MIN) begin
            sat = pgds_pkg::CELL_W'(pgds_pkg::SAT_MIN);
        end else begin
            sat = res[pgds_pkg::CELL_W-1:0];
        end
    end

    // result word, strobed for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= (r_state == pgds_pkg::ST_RND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pgds_pkg::ST_RND) begin
            o_updated_value <= sat;
            o_is_last       <= r_last;
        end
    end

endmodule

@@ hdl/pgds_checker.sv @@
module pgds_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_operation,
    input logic o_result_valid
);

    // an accepted emit makes the block busy
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_operation == pgds_pkg::OP_EMIT) |=> busy)
        else $error("emit accepted but block not busy");

    // a load finishes in the cycle it is accepted
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_operation == pgds_pkg::OP_LOAD) |=> !busy)
        else $error("load left block busy");

    // a result word follows a busy period
    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a busy period");

    // the block is free while a result word is shown
    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    // no two result words back to back
    a_res_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for two cycles");

endmodule

bind periodic_grid_diffusion_step pgds_checker u_pgds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_operation   (i_operation),
    .o_result_valid(o_result_valid)
);
